/* rtl/lslf_pkg.sv */
package lslf_pkg;

  localparam int SAMPLE_WIDTH       = 16;
  localparam int RESULT_WIDTH       = 32;
  localparam int MAX_POINTS_DEFAULT = 1024;
  localparam int DIGIT_WIDTH        = 16;
  localparam int QUEUE_DEPTH        = 2;
  localparam int INTERCEPT_SHIFT    = 8;
  localparam int SLOPE_SHIFT        = 16;

  typedef enum logic [1:0] {
    FIT_OK       = 2'd0,
    FIT_DET_ZERO = 2'd1,
    FIT_TOO_MANY = 2'd2
  } fit_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MLOAD,
    ST_MMUL,
    ST_MACC,
    ST_DCHK,
    ST_DLOAD,
    ST_DIV,
    ST_DFIN,
    ST_OUT
  } back_state_e;

  // product terms, in evaluation order
  typedef enum logic [2:0] {
    TERM_N_SXX,
    TERM_SX_SX,
    TERM_SY_SXX,
    TERM_SX_SXY,
    TERM_N_SXY,
    TERM_SX_SY
  } term_e;

  function automatic int count_width(input int max_points);
    return $clog2(max_points + 1);
  endfunction

  function automatic int sum_width(input int max_points);
    return SAMPLE_WIDTH + count_width(max_points);
  endfunction

  function automatic int prod_sum_width(input int max_points);
    return 2 * SAMPLE_WIDTH - 1 + count_width(max_points);
  endfunction

  function automatic int job_width(input int max_points);
    return count_width(max_points) + 2 * sum_width(max_points)
           + 2 * prod_sum_width(max_points) + 1;
  endfunction

endpackage

/* rtl/lslf_sample_if.sv */
interface lslf_sample_if;
  import lslf_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] x_sample;
  logic signed [SAMPLE_WIDTH-1:0] y_sample;
  logic                           last_point;

  modport source (output valid, x_sample, y_sample, last_point, input ready);
  modport sink   (input valid, x_sample, y_sample, last_point, output ready);
endinterface

/* rtl/lslf_fit_if.sv */
interface lslf_fit_if;
  import lslf_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [RESULT_WIDTH-1:0] intercept;
  logic signed [RESULT_WIDTH-1:0] slope;
  logic [1:0]                     fit_status;

  modport source (output valid, intercept, slope, fit_status, input ready);
  modport sink   (input valid, intercept, slope, fit_status, output ready);
endinterface

/* rtl/lslf_front.sv */
module lslf_front #(
  parameter int MAX_POINTS = lslf_pkg::MAX_POINTS_DEFAULT
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  lslf_sample_if.sink                               sample_i,
  output logic                                      push_o,
  output logic [lslf_pkg::job_width(MAX_POINTS)-1:0] job_o,
  input  logic                                      full_i
);
  import lslf_pkg::*;

  localparam int CW = count_width(MAX_POINTS);
  localparam int SW = sum_width(MAX_POINTS);
  localparam int PW = prod_sum_width(MAX_POINTS);
  localparam int MW = 2 * SAMPLE_WIDTH;

  typedef struct packed {
    logic [CW-1:0]        count;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic signed [PW-1:0] sum_xy;
    logic signed [PW-1:0] sum_xx;
    logic                 ovf;
  } job_t;

  logic                           s1_valid_q;
  logic                           s1_last_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_x_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_y_q;
  logic signed [MW-1:0]           s1_xy_q;
  logic signed [MW-1:0]           s1_xx_q;

  logic [CW-1:0]        count_q;
  logic signed [SW-1:0] sum_x_q;
  logic signed [SW-1:0] sum_y_q;
  logic signed [PW-1:0] sum_xy_q;
  logic signed [PW-1:0] sum_xx_q;
  logic                 ovf_q;

  logic advance;
  logic accept;
  logic in_range;
  job_t job_d;

  assign advance        = s1_valid_q && !(s1_last_q && full_i);
  assign sample_i.ready = !s1_valid_q || advance;
  assign accept         = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q    <= sample_i.x_sample;
      s1_y_q    <= sample_i.y_sample;
      s1_last_q <= sample_i.last_point;
      s1_xy_q   <= sample_i.x_sample * sample_i.y_sample;
      s1_xx_q   <= sample_i.x_sample * sample_i.x_sample;
    end
  end

  always_comb begin
    in_range = count_q < CW'(MAX_POINTS);
    job_d    = '{count: count_q, sum_x: sum_x_q, sum_y: sum_y_q,
                 sum_xy: sum_xy_q, sum_xx: sum_xx_q, ovf: ovf_q | !in_range};
    if (in_range) begin
      job_d.count  = count_q + CW'(1);
      job_d.sum_x  = sum_x_q + SW'(s1_x_q);
      job_d.sum_y  = sum_y_q + SW'(s1_y_q);
      job_d.sum_xy = sum_xy_q + PW'(s1_xy_q);
      job_d.sum_xx = sum_xx_q + PW'(s1_xx_q);
    end
  end

  assign push_o = advance && s1_last_q;
  assign job_o  = job_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      count_q    <= '0;
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      sum_xy_q   <= '0;
      sum_xx_q   <= '0;
      ovf_q      <= 1'b0;
    end else begin
      if (sample_i.ready) begin
        s1_valid_q <= sample_i.valid;
      end
      if (advance) begin
        if (s1_last_q) begin
          count_q  <= '0;
          sum_x_q  <= '0;
          sum_y_q  <= '0;
          sum_xy_q <= '0;
          sum_xx_q <= '0;
          ovf_q    <= 1'b0;
        end else begin
          count_q  <= job_d.count;
          sum_x_q  <= job_d.sum_x;
          sum_y_q  <= job_d.sum_y;
          sum_xy_q <= job_d.sum_xy;
          sum_xx_q <= job_d.sum_xx;
          ovf_q    <= job_d.ovf;
        end
      end
    end
  end

endmodule

/* rtl/lslf_queue.sv */
module lslf_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  import lslf_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = fill_q == FILL_W'(QUEUE_DEPTH);
  assign empty_o = fill_q == '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

endmodule

/* rtl/lslf_back.sv */
module lslf_back #(
  parameter int MAX_POINTS = lslf_pkg::MAX_POINTS_DEFAULT
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      empty_i,
  input  logic [lslf_pkg::job_width(MAX_POINTS)-1:0] job_i,
  output logic                                      pop_o,
  lslf_fit_if.source                                fit_o
);
  import lslf_pkg::*;

  localparam int CW   = count_width(MAX_POINTS);
  localparam int SW   = sum_width(MAX_POINTS);
  localparam int PW   = prod_sum_width(MAX_POINTS);
  localparam int AW   = SW + PW + 1;
  localparam int NW   = AW + SLOPE_SHIFT;
  localparam int NDIG = (PW + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
  localparam int BW   = NDIG * DIGIT_WIDTH;
  localparam int PRW  = SW + BW;
  localparam int DGW  = $clog2(NDIG);
  localparam int NCW  = $clog2(NW);
  localparam int RW   = RESULT_WIDTH;

  localparam logic [RW-1:0] SAT_MAX = {1'b0, {(RW - 1){1'b1}}};
  localparam logic [RW-1:0] SAT_MIN = {1'b1, {(RW - 1){1'b0}}};

  typedef struct packed {
    logic [CW-1:0]        count;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic signed [PW-1:0] sum_xy;
    logic signed [PW-1:0] sum_xx;
    logic                 ovf;
  } job_t;

  back_state_e state_q, state_d;
  job_t        job_q;
  term_e       term_q;

  logic [SW-1:0]        amag_q;
  logic [BW-1:0]        bmag_q;
  logic                 neg_q;
  logic [PRW-1:0]       prod_q;
  logic [DGW-1:0]       dig_q;
  logic signed [AW-1:0] acc_q;
  logic signed [AW-1:0] det_q;
  logic signed [AW-1:0] na_q;

  logic [NW-1:0] nmag_q;
  logic [AW-1:0] dmag_q;
  logic [AW-1:0] rem_q;
  logic [RW:0]   quo_q;
  logic          qovf_q;
  logic          qneg_q;
  logic          div_sel_q;
  logic [NCW-1:0] cnt_q;

  logic [RW-1:0] intercept_q;
  logic [RW-1:0] slope_q;
  fit_status_e   status_q;

  logic signed [SW-1:0]      op_a;
  logic signed [PW-1:0]      op_b;
  logic                      op_sub;
  logic [SW-1:0]             a_abs;
  logic [PW-1:0]             b_abs;
  logic [DIGIT_WIDTH-1:0]    digit;
  logic [SW+DIGIT_WIDTH-1:0] pp;
  logic [PRW-1:0]            prod_d;
  logic signed [AW-1:0]      prod_ext;
  logic signed [AW-1:0]      acc_sum;
  logic [AW:0]               trial;
  logic                      fits;
  logic [AW-1:0]             rem_next;
  logic signed [AW-1:0]      num_sel;
  logic [AW-1:0]             num_abs;
  logic [AW-1:0]             det_abs;
  logic                      pos_sat;
  logic                      neg_sat;
  logic [RW-1:0]             div_res;

  always_comb begin
    op_a   = SW'(job_q.count);
    op_b   = job_q.sum_xx;
    op_sub = 1'b0;
    case (term_q)
      TERM_N_SXX: begin
        op_a = SW'(job_q.count);
        op_b = job_q.sum_xx;
      end
      TERM_SX_SX: begin
        op_a   = job_q.sum_x;
        op_b   = PW'(job_q.sum_x);
        op_sub = 1'b1;
      end
      TERM_SY_SXX: begin
        op_a = job_q.sum_y;
        op_b = job_q.sum_xx;
      end
      TERM_SX_SXY: begin
        op_a   = job_q.sum_x;
        op_b   = job_q.sum_xy;
        op_sub = 1'b1;
      end
      TERM_N_SXY: begin
        op_a = SW'(job_q.count);
        op_b = job_q.sum_xy;
      end
      TERM_SX_SY: begin
        op_a   = job_q.sum_x;
        op_b   = PW'(job_q.sum_y);
        op_sub = 1'b1;
      end
      default: begin
        op_a = SW'(job_q.count);
        op_b = job_q.sum_xx;
      end
    endcase
  end

  assign a_abs    = op_a[SW-1] ? -op_a : op_a;
  assign b_abs    = op_b[PW-1] ? -op_b : op_b;
  assign digit    = bmag_q[BW-1 -: DIGIT_WIDTH];
  assign pp       = {{DIGIT_WIDTH{1'b0}}, amag_q} * {{SW{1'b0}}, digit};
  assign prod_d   = (prod_q << DIGIT_WIDTH) + PRW'(pp);
  assign prod_ext = AW'(prod_q);
  assign acc_sum  = acc_q + (neg_q ? -prod_ext : prod_ext);

  // restoring division, one quotient bit per cycle
  assign trial    = {rem_q, nmag_q[NW-1]};
  assign fits     = trial >= {1'b0, dmag_q};
  assign rem_next = fits ? AW'(trial - {1'b0, dmag_q}) : AW'(trial);
  assign num_sel  = div_sel_q ? acc_q : na_q;
  assign num_abs  = num_sel[AW-1] ? -num_sel : num_sel;
  assign det_abs  = det_q[AW-1] ? -det_q : det_q;

  assign pos_sat = qovf_q | quo_q[RW] | quo_q[RW-1];
  assign neg_sat = qovf_q | quo_q[RW] | (quo_q[RW-1] & (|quo_q[RW-2:0]));
  assign div_res = qneg_q ? (neg_sat ? SAT_MIN : -quo_q[RW-1:0])
                          : (pos_sat ? SAT_MAX : quo_q[RW-1:0]);

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = ST_MLOAD;
        end
      end
      ST_MLOAD: state_d = ST_MMUL;
      ST_MMUL: begin
        if (dig_q == DGW'(NDIG - 1)) begin
          state_d = ST_MACC;
        end
      end
      ST_MACC: begin
        case (term_q)
          TERM_SX_SX: state_d = ST_DCHK;
          TERM_SX_SY: state_d = ST_DLOAD;
          default:    state_d = ST_MLOAD;
        endcase
      end
      ST_DCHK:  state_d = (det_q == '0) ? ST_OUT : ST_MLOAD;
      ST_DLOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_DFIN;
        end
      end
      ST_DFIN: state_d = div_sel_q ? ST_OUT : ST_DLOAD;
      ST_OUT: begin
        if (fit_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        job_q  <= job_i;
        term_q <= TERM_N_SXX;
        acc_q  <= '0;
      end
      ST_MLOAD: begin
        amag_q <= a_abs;
        bmag_q <= BW'(b_abs);
        neg_q  <= op_a[SW-1] ^ op_b[PW-1] ^ op_sub;
        prod_q <= '0;
        dig_q  <= '0;
      end
      ST_MMUL: begin
        prod_q <= prod_d;
        bmag_q <= bmag_q << DIGIT_WIDTH;
        dig_q  <= dig_q + DGW'(1);
      end
      ST_MACC: begin
        case (term_q)
          TERM_N_SXX: begin
            acc_q  <= acc_sum;
            term_q <= TERM_SX_SX;
          end
          TERM_SX_SX: begin
            det_q <= acc_sum;
            acc_q <= '0;
          end
          TERM_SY_SXX: begin
            acc_q  <= acc_sum;
            term_q <= TERM_SX_SXY;
          end
          TERM_SX_SXY: begin
            na_q   <= acc_sum;
            acc_q  <= '0;
            term_q <= TERM_N_SXY;
          end
          TERM_N_SXY: begin
            acc_q  <= acc_sum;
            term_q <= TERM_SX_SY;
          end
          TERM_SX_SY: begin
            acc_q     <= acc_sum;
            div_sel_q <= 1'b0;
          end
          default: acc_q <= acc_q;
        endcase
      end
      ST_DCHK: begin
        if (det_q == '0) begin
          intercept_q <= '0;
          slope_q     <= '0;
          status_q    <= FIT_DET_ZERO;
        end else begin
          term_q <= TERM_SY_SXX;
        end
      end
      ST_DLOAD: begin
        nmag_q <= div_sel_q ? (NW'(num_abs) << SLOPE_SHIFT)
                            : (NW'(num_abs) << INTERCEPT_SHIFT);
        dmag_q <= det_abs;
        rem_q  <= '0;
        quo_q  <= '0;
        qovf_q <= 1'b0;
        qneg_q <= num_sel[AW-1] ^ det_q[AW-1];
        cnt_q  <= NCW'(NW - 1);
      end
      ST_DIV: begin
        nmag_q <= nmag_q << 1;
        rem_q  <= rem_next;
        quo_q  <= {quo_q[RW-1:0], fits};
        qovf_q <= qovf_q | quo_q[RW];
        cnt_q  <= cnt_q - NCW'(1);
      end
      ST_DFIN: begin
        if (div_sel_q) begin
          slope_q  <= div_res;
          status_q <= job_q.ovf ? FIT_TOO_MANY : FIT_OK;
        end else begin
          intercept_q <= div_res;
          div_sel_q   <= 1'b1;
        end
      end
      default: acc_q <= acc_q;
    endcase
  end

  assign fit_o.valid      = state_q == ST_OUT;
  assign fit_o.intercept  = intercept_q;
  assign fit_o.slope      = slope_q;
  assign fit_o.fit_status = status_q;

endmodule

/* rtl/least_squares_line_fit_top.sv */
// Least-squares straight-line fit over a stream of signed Q8.8 (x, y) pairs.
// sample_i: valid/ready channel of pairs; last_point closes a data set.
// fit_o:    valid/ready channel, one transaction per data set: intercept and
//           slope in signed Q16.16 (saturated) and fit_status.
// Throughput: one pair per cycle while no last pair is held by a full queue. The
// front accumulates count and sums in a two-stage pipe and pushes each closed
// data set into a two-entry queue; the back evaluates six products with a
// 16-bit digit multiplier, then two restoring divisions at one quotient bit
// per cycle over the shifted numerator. A zero determinant skips the divisions.
// While a result waits on fit_o.ready, the front keeps taking pairs; it
// stalls on a last pair only when two data sets are already queued.
// Reset clears the sums, the queue and the sequencer; no result is pending.
module least_squares_line_fit_top #(
  parameter int MAX_POINTS = lslf_pkg::MAX_POINTS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lslf_sample_if.sink sample_i,
  lslf_fit_if.source  fit_o
);
  import lslf_pkg::*;

  localparam int JW = job_width(MAX_POINTS);

  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  logic [JW-1:0] job_in;
  logic [JW-1:0] job_out;

  lslf_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_i),
    .push_o  (push),
    .job_o   (job_in),
    .full_i  (full)
  );

  lslf_queue #(
    .WIDTH(JW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (job_out)
  );

  lslf_back #(
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(empty),
    .job_i  (job_out),
    .pop_o  (pop),
    .fit_o  (fit_o)
  );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import lslf_pkg::*;

  localparam int MAX_PTS      = MAX_POINTS_DEFAULT;
  localparam int RANDOM_PAIRS = 120;
  localparam logic signed [127:0] Q16_HI = (128'sd1 <<< 31) - 128'sd1;
  localparam logic signed [127:0] Q16_LO = -(128'sd1 <<< 31);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [RESULT_WIDTH-1:0] q16_t;

  typedef struct {
    q16_t        intercept;
    q16_t        slope;
    fit_status_e status;
  } line_fit_t;

  typedef enum int {SET_SCATTER, SET_FLAT_X, SET_LINE} set_shape_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  lslf_sample_if sample_bus ();
  lslf_fit_if    fit_bus ();

  least_squares_line_fit_top #(
    .MAX_POINTS(MAX_PTS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_bus),
    .fit_o   (fit_bus)
  );

  always #5 clk_i = ~clk_i;

  // running sums of the data set being collected
  int     pts;
  longint sum_x, sum_y, sum_xy, sum_xx;
  bit     past_limit;

  line_fit_t pending_fits[$];

  int pairs_sent     = 0;
  int fits_checked   = 0;
  int fits_det_zero  = 0;
  int fits_too_many  = 0;
  int mismatch_count = 0;
  int hold_cycles    = 0;
  bit no_idle        = 1'b0;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic q16_t saturate_q16(input logic signed [127:0] q);
    if (q > Q16_HI) return q16_t'(Q16_HI);
    if (q < Q16_LO) return q16_t'(Q16_LO);
    return q16_t'(q);
  endfunction

  function automatic void clear_sums();
    pts        = 0;
    sum_x      = 0;
    sum_y      = 0;
    sum_xy     = 0;
    sum_xx     = 0;
    past_limit = 1'b0;
  endfunction

  function automatic void accumulate_pair(input sample_t x, input sample_t y, input logic last);
    logic signed [127:0] n_w, sx_w, sy_w, sxy_w, sxx_w, det, num_a, num_b;
    line_fit_t fit;
    if (pts < MAX_PTS) begin
      sum_x  += longint'(x);
      sum_y  += longint'(y);
      sum_xy += longint'(x) * longint'(y);
      sum_xx += longint'(x) * longint'(x);
      pts++;
    end else begin
      past_limit = 1'b1;
    end
    if (!last) return;
    n_w   = pts;
    sx_w  = sum_x;
    sy_w  = sum_y;
    sxy_w = sum_xy;
    sxx_w = sum_xx;
    det   = n_w * sxx_w - sx_w * sx_w;
    if (det == 0) begin
      fit.intercept = '0;
      fit.slope     = '0;
      fit.status    = FIT_DET_ZERO;
    end else begin
      num_a = (sy_w * sxx_w - sx_w * sxy_w) <<< INTERCEPT_SHIFT;
      num_b = (n_w * sxy_w - sx_w * sy_w) <<< SLOPE_SHIFT;
      fit.intercept = saturate_q16(num_a / det);
      fit.slope     = saturate_q16(num_b / det);
      fit.status    = past_limit ? FIT_TOO_MANY : FIT_OK;
    end
    pending_fits.push_back(fit);
    clear_sums();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_fit();
    line_fit_t want;
    if (pending_fits.size() == 0) begin
      report_mismatch($sformatf("fit with none pending (a=%0d b=%0d st=%0d)",
                                fit_bus.intercept, fit_bus.slope, fit_bus.fit_status));
      return;
    end
    want = pending_fits.pop_front();
    fits_checked++;
    if (want.status == FIT_DET_ZERO) fits_det_zero++;
    if (want.status == FIT_TOO_MANY) fits_too_many++;
    if (fit_bus.intercept !== want.intercept)
      report_mismatch($sformatf("fit %0d intercept got %0d want %0d",
                                fits_checked, fit_bus.intercept, want.intercept));
    if (fit_bus.slope !== want.slope)
      report_mismatch($sformatf("fit %0d slope got %0d want %0d",
                                fits_checked, fit_bus.slope, want.slope));
    if (fit_bus.fit_status !== want.status)
      report_mismatch($sformatf("fit %0d status got %0d want %s",
                                fits_checked, fit_bus.fit_status, want.status.name()));
  endtask

  task automatic send_pair(input sample_t x, input sample_t y, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_bus.valid      <= 1'b1;
    sample_bus.x_sample   <= x;
    sample_bus.y_sample   <= y;
    sample_bus.last_point <= last;
    do @(posedge clk_i); while (!sample_bus.ready);
    pairs_sent++;
    accumulate_pair(x, y, last);
  endtask

  task automatic wait_for_fits();
    sample_bus.valid <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_set(input int n, input set_shape_e shape);
    sample_t fx, x, y;
    int      slope_n, offset, xi, yi;
    fx      = sample_t'($urandom);
    slope_n = $urandom_range(16) - 8;
    offset  = $urandom_range(8000) - 4000;
    for (int i = 0; i < n; i++) begin
      case (shape)
        SET_FLAT_X: begin
          x = fx;
          y = sample_t'($urandom);
        end
        SET_LINE: begin
          xi = $urandom_range(16000) - 8000;
          yi = xi * slope_n / 4 + offset + int'($urandom_range(64)) - 32;
          if (yi > 32767) yi = 32767;
          if (yi < -32768) yi = -32768;
          x = sample_t'(xi);
          y = sample_t'(yi);
        end
        default: begin
          x = sample_t'($urandom);
          y = sample_t'($urandom);
        end
      endcase
      send_pair(x, y, i == n - 1);
    end
  endtask

  task automatic test_directed();
    // single points: zero determinant
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    // constant x
    send_pair(16'sd100, 16'sd5, 1'b0);
    send_pair(16'sd100, -16'sd7, 1'b0);
    send_pair(16'sd100, 16'sd9, 1'b1);
    // y = 2x + 1
    send_pair(16'sd0, 16'sd256, 1'b0);
    send_pair(16'sd256, 16'sd768, 1'b1);
    // full-scale corners
    send_pair(-16'sd32768, -16'sd32768, 1'b0);
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b0);
    send_pair(16'sd32767, -16'sd32768, 1'b1);
    // slope saturates high, then low
    send_pair(16'sd0, -16'sd32768, 1'b0);
    send_pair(16'sd1, 16'sd32767, 1'b1);
    send_pair(16'sd0, 16'sd32767, 1'b0);
    send_pair(16'sd1, -16'sd32768, 1'b1);
    // both saturate, far from the origin
    send_pair(16'sd32766, -16'sd32768, 1'b0);
    send_pair(16'sd32767, 16'sd32767, 1'b1);
    wait_for_fits();
  endtask

  task automatic test_backpressure();
    hold_cycles = 1500;
    no_idle     = 1'b1;
    for (int s = 0; s < 6; s++) send_set(5, SET_SCATTER);
    no_idle = 1'b0;
    wait_for_fits();
  endtask

  task automatic test_too_many_points();
    send_set(MAX_PTS + 2, SET_SCATTER);
    wait_for_fits();
    // flat x over the counted pairs: zero determinant wins over the limit
    for (int i = 0; i < MAX_PTS; i++) send_pair(-16'sd300, sample_t'($urandom), 1'b0);
    for (int i = 0; i < 2; i++) send_pair(sample_t'($urandom), sample_t'($urandom), i == 1);
    wait_for_fits();
  endtask

  task automatic test_random();
    int         stop_at, r, n;
    set_shape_e shape;
    stop_at = pairs_sent + RANDOM_PAIRS;
    while (pairs_sent < stop_at) begin
      r       = $urandom_range(99);
      no_idle = ($urandom_range(99) < 15);
      n       = $urandom_range(2, 24);
      if (r < 10) shape = SET_FLAT_X;
      else if (r < 50) shape = SET_LINE;
      else shape = SET_SCATTER;
      if (r >= 10 && r < 15) n = 1;
      if (r >= 97) n = $urandom_range(100, 300);
      send_set(n, shape);
    end
    no_idle = 1'b0;
    wait_for_fits();
  endtask

  // result side: random stalls plus a long hold on request
  initial begin
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (fit_bus.valid && fit_bus.ready) check_fit();
      if (hold_cycles > 0) begin
        fit_bus.ready <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        fit_bus.ready <= 1'b0;
        stall--;
      end else begin
        fit_bus.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d fits outstanding", pending_fits.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    clear_sums();
    sample_bus.valid      <= 1'b0;
    sample_bus.x_sample   <= '0;
    sample_bus.y_sample   <= '0;
    sample_bus.last_point <= 1'b0;
    fit_bus.ready         <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_too_many_points();
    test_random();
    repeat (300) @(posedge clk_i);
    $display("covered %0d sample pairs in %0d fits: %0d with zero determinant, %0d past the limit",
             pairs_sent, fits_checked, fits_det_zero, fits_too_many);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lslf_pkg.sv
rtl/lslf_sample_if.sv
rtl/lslf_fit_if.sv
rtl/lslf_front.sv
rtl/lslf_queue.sv
rtl/lslf_back.sv
rtl/least_squares_line_fit_top.sv
bench/testbench.sv
